### rtl/core/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, constants and helpers for the percent escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ped_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned NOUT = 3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_DIGIT = 2'd2
  } mode_t;

  // Decoded words produced by one input word
  typedef struct packed {
    logic [NOUT-1:0][7:0] data;
    logic [1:0]           cnt;
    logic                 fin;
  } bnd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/ped_decode.sv
// ----------------------------------------------------------------------------
// ped_decode
// Escape state machine: turns one raw word into zero to three decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_decode
  import ped_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] raw_byte,
  input  wire logic       raw_final,
  output bnd_t            bnd
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= 8'h00;
    end else if (step) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

  always_comb begin
    logic [1:0] n;
    logic       refresh;
    n        = 2'd0;
    refresh  = 1'b0;
    mode_nxt = mode_r;
    held_nxt = held_r;
    bnd.data = '0;

    unique case (mode_r)
      MODE_PCT: begin
        if (is_hex(raw_byte)) begin
          held_nxt = raw_byte;
          mode_nxt = MODE_DIGIT;
        end else begin
          bnd.data[n] = PCT_CHAR;
          n           = n + 2'd1;
          refresh     = 1'b1;
        end
      end
      MODE_DIGIT: begin
        if (is_hex(raw_byte)) begin
          bnd.data[n] = {hex_val(held_r), hex_val(raw_byte)};
          n           = n + 2'd1;
          mode_nxt    = MODE_IDLE;
          held_nxt    = 8'h00;
        end else begin
          bnd.data[n] = PCT_CHAR;
          n           = n + 2'd1;
          bnd.data[n] = held_r;
          n           = n + 2'd1;
          held_nxt    = 8'h00;
          refresh     = 1'b1;
        end
      end
      default: refresh = 1'b1;
    endcase

    // re-examine the word as if idle
    if (refresh) begin
      if (raw_byte == PCT_CHAR) begin
        mode_nxt = MODE_PCT;
      end else begin
        bnd.data[n] = raw_byte;
        n           = n + 2'd1;
        mode_nxt    = MODE_IDLE;
      end
    end

    // end of string: flush pending escape literally
    if (raw_final) begin
      unique case (mode_nxt)
        MODE_PCT: begin
          bnd.data[n] = PCT_CHAR;
          n           = n + 2'd1;
        end
        MODE_DIGIT: begin
          bnd.data[n] = PCT_CHAR;
          n           = n + 2'd1;
          bnd.data[n] = held_nxt;
          n           = n + 2'd1;
        end
        default: ;
      endcase
      mode_nxt = MODE_IDLE;
      held_nxt = 8'h00;
    end

    bnd.cnt = n;
    bnd.fin = raw_final;
  end

`ifndef ASSERT_OFF
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && raw_final |=> mode_r == MODE_IDLE && held_r == 8'h00)
    else $error("mode not idle after end of string");
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_DIGIT |-> held_r == 8'h00)
    else $error("held digit set outside digit mode");
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step && raw_final |-> bnd.cnt != 2'd0)
    else $error("final word produced no output");
`endif

endmodule

`default_nettype wire

### rtl/core/ped_out_buf.sv
// ----------------------------------------------------------------------------
// ped_out_buf
// Result register: holds a decoded group, sends one word a cycle on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_out_buf
  import ped_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire bnd_t       load_bnd,
  output logic            load_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);

  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  bnd_t       bnd_r;
  logic       last;

  assign last           = (idx_r == bnd_r.cnt - 2'd1);
  assign load_ready     = !vld_r || (out_ready && last);
  assign out_valid      = vld_r;
  assign out_byte       = bnd_r.data[idx_r];
  assign out_run_last   = last;
  assign out_string_end = last && bnd_r.fin;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (vld_r && out_ready) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= load_bnd;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> bnd_r.cnt != 2'd0)
    else $error("empty group held");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> idx_r < bnd_r.cnt)
    else $error("index past group");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> load_ready)
    else $error("group overwritten before drained");
`endif

endmodule

`default_nettype wire

### rtl/core/percent_escape_decoder.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Percent decoding of a byte string, one raw word per cycle unless stalled.
// ----------------------------------------------------------------------------
// A raw word is registered, decoded in one pass, and its zero to three result
// words are held in an output register that sends one word per cycle while
// out_ready is high. A word that gives at most one result does not stall the
// input, so a string with well formed escapes streams at one word per cycle
// while out_ready is high; a broken escape or an end-of-string flush gives up
// to three results and the input then waits while the output register drains
// them. A raw word passes the input register and then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_escape_decoder
  import ped_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);

  logic       ir_vld_r;
  logic [7:0] ir_byte_r;
  logic       ir_final_r;
  logic       step;
  logic       load_ready;
  bnd_t       bnd;

  assign step     = ir_vld_r && (bnd.cnt == 2'd0 || load_ready);
  assign in_ready = !ir_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r <= 1'b0;
    end else if (in_ready) begin
      ir_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte_r  <= in_byte;
      ir_final_r <= in_final;
    end
  end

  ped_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .raw_byte  (ir_byte_r),
    .raw_final (ir_final_r),
    .bnd       (bnd)
  );

  ped_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (step && bnd.cnt != 2'd0),
    .load_bnd       (bnd),
    .load_ready     (load_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
